[design/ntfsrl_pkg.sv]
`default_nettype none

package ntfsrl_pkg;

  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_START_VCN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_END_VCN   = CFG_IDX_W'(1);

  localparam logic [3:0] MAX_FIELD_BYTES = 4'd8;

  typedef enum logic [1:0] {
    KIND_RUN     = 2'd0,
    KIND_END     = 2'd1,
    KIND_CORRUPT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_COUNT  = 2'd1,
    PH_DELTA  = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] run_vcn;
    logic [63:0] run_clusters;
    logic [63:0] run_lcn;
    logic        is_sparse;
    logic        final_res;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    logic [63:0] start_vcn;
    logic [63:0] end_vcn;
    logic [63:0] end_p1;
    logic        end_max;
  } cfg_t;

  function automatic result_t final_result(input kind_t kind);
    result_t r;
    r = '0;
    r.kind = kind;
    r.final_res = 1'b1;
    return r;
  endfunction

  // The end of a list is corrupt when runs were decoded, the end check is
  // enabled, and the running VCN does not land one past the expected end.
  function automatic kind_t end_kind(input logic any_runs, input cfg_t c,
                                     input logic [63:0] vcn);
    if (any_runs && (c.end_vcn >= c.start_vcn) && (c.end_max || (vcn != c.end_p1))) begin
      return KIND_CORRUPT;
    end
    return KIND_END;
  endfunction

  function automatic logic [63:0] sext_delta(input logic [63:0] d, input logic [3:0] nbytes);
    logic [63:0] r;
    r = d;
    case (nbytes)
      4'd1: r = {{56{d[7]}}, d[7:0]};
      4'd2: r = {{48{d[15]}}, d[15:0]};
      4'd3: r = {{40{d[23]}}, d[23:0]};
      4'd4: r = {{32{d[31]}}, d[31:0]};
      4'd5: r = {{24{d[39]}}, d[39:0]};
      4'd6: r = {{16{d[47]}}, d[47:0]};
      4'd7: r = {{8{d[55]}}, d[55:0]};
      default: r = d;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[design/ntfsrl_in_if.sv]
`default_nettype none

interface ntfsrl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input first_byte, input last_byte,
                output ready);
endinterface

`default_nettype wire

[design/ntfsrl_out_if.sv]
`default_nettype none

interface ntfsrl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] run_vcn;
  logic [63:0] run_clusters;
  logic [63:0] run_lcn;
  logic        is_sparse;
  logic        final_res;

  modport source (output valid, output kind, output run_vcn, output run_clusters,
                  output run_lcn, output is_sparse, output final_res, input ready);
  modport sink (input valid, input kind, input run_vcn, input run_clusters,
                input run_lcn, input is_sparse, input final_res, output ready);
endinterface

`default_nettype wire

[design/ntfsrl_cfg_if.sv]
`default_nettype none

interface ntfsrl_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/ntfsrl_core.sv]
`default_nettype none

module ntfsrl_core #(
  parameter int MAX_RUNS = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             first_byte,
  input  logic             last_byte,
  input  ntfsrl_pkg::cfg_t cfg_regs,
  output ntfsrl_pkg::push_t push
);
  import ntfsrl_pkg::*;

  localparam int RT_W = $clog2(MAX_RUNS + 1);

  phase_t      phase, phase_next, ph_e;
  logic [3:0]  bytes_left, bytes_left_next, bl_e, bl_dec;
  logic [3:0]  off_bytes, off_bytes_next;
  logic [2:0]  byte_index, byte_index_next, bi_e, bi_inc;
  logic [63:0] assembled_count, assembled_count_next, cnt_e, cnt_sh, cnt_use;
  logic [63:0] assembled_delta, assembled_delta_next, dlt_e, dlt_sh, dlt_use;
  logic [63:0] running_vcn, running_vcn_next, rv_e;
  logic [63:0] running_lcn, running_lcn_next, rl_e;
  logic [RT_W-1:0] run_total, run_total_next, rt_e, rt_inc;

  logic [63:0] byte_sh, d_ext;
  logic [64:0] lsum, vsum;
  logic        sparse, lcn_bad, run_bad, complete;
  logic [3:0]  len_sz, off_sz;

  // A first byte restarts the list before the byte itself is decoded.
  assign ph_e  = first_byte ? PH_HEADER : phase;
  assign bl_e  = first_byte ? 4'd0 : bytes_left;
  assign bi_e  = first_byte ? 3'd0 : byte_index;
  assign cnt_e = first_byte ? 64'd0 : assembled_count;
  assign dlt_e = first_byte ? 64'd0 : assembled_delta;
  assign rv_e  = first_byte ? cfg_regs.start_vcn : running_vcn;
  assign rl_e  = first_byte ? 64'd0 : running_lcn;
  assign rt_e  = first_byte ? '0 : run_total;

  assign len_sz  = data_byte[3:0];
  assign off_sz  = data_byte[7:4];
  assign byte_sh = 64'(data_byte) << {bi_e, 3'b000};
  assign cnt_sh  = cnt_e | byte_sh;
  assign dlt_sh  = dlt_e | byte_sh;
  assign bl_dec  = bl_e - 4'd1;
  assign bi_inc  = bi_e + 3'd1;
  assign cnt_use = (ph_e == PH_COUNT) ? cnt_sh : cnt_e;
  assign dlt_use = (ph_e == PH_DELTA) ? dlt_sh : dlt_e;

  assign sparse  = (off_bytes == 4'd0);
  assign d_ext   = sext_delta(dlt_use, off_bytes);
  assign lsum    = {1'b0, rl_e} + {1'b0, d_ext};
  assign vsum    = {1'b0, rv_e} + {1'b0, cnt_use};
  // A negative delta underflows exactly when the sum produces no carry.
  assign lcn_bad = !sparse && (d_ext[63] ? !lsum[64] : lsum[64]);
  assign run_bad = lcn_bad || vsum[64] || (rt_e >= RT_W'(MAX_RUNS));
  assign rt_inc  = rt_e + RT_W'(1);

  always_comb begin
    phase_next           = ph_e;
    bytes_left_next      = bl_e;
    off_bytes_next       = off_bytes;
    byte_index_next      = bi_e;
    assembled_count_next = cnt_e;
    assembled_delta_next = dlt_e;
    running_vcn_next     = rv_e;
    running_lcn_next     = rl_e;
    run_total_next       = rt_e;
    push                 = '0;
    complete             = 1'b0;

    unique case (ph_e)
      PH_HEADER: begin
        if (data_byte == 8'd0) begin
          push.n     = 2'd1;
          push.r0    = final_result(end_kind(rt_e != '0, cfg_regs, rv_e));
          phase_next = PH_DONE;
        end else if (len_sz == 4'd0 || len_sz > MAX_FIELD_BYTES ||
                     off_sz > MAX_FIELD_BYTES) begin
          push.n     = 2'd1;
          push.r0    = final_result(KIND_CORRUPT);
          phase_next = PH_DONE;
        end else begin
          off_bytes_next       = off_sz;
          byte_index_next      = 3'd0;
          bytes_left_next      = len_sz;
          assembled_count_next = 64'd0;
          assembled_delta_next = 64'd0;
          phase_next           = PH_COUNT;
          if (last_byte) begin
            push.n     = 2'd1;
            push.r0    = final_result(KIND_CORRUPT);
            phase_next = PH_DONE;
          end
        end
      end
      PH_COUNT: begin
        assembled_count_next = cnt_sh;
        byte_index_next      = bi_inc;
        bytes_left_next      = bl_dec;
        if (bl_dec == 4'd0 && cnt_sh == 64'd0) begin
          push.n     = 2'd1;
          push.r0    = final_result(KIND_CORRUPT);
          phase_next = PH_DONE;
        end else if (bl_dec == 4'd0 && sparse) begin
          complete = 1'b1;
        end else begin
          if (bl_dec == 4'd0) begin
            phase_next      = PH_DELTA;
            byte_index_next = 3'd0;
            bytes_left_next = off_bytes;
          end
          if (last_byte) begin
            push.n     = 2'd1;
            push.r0    = final_result(KIND_CORRUPT);
            phase_next = PH_DONE;
          end
        end
      end
      PH_DELTA: begin
        assembled_delta_next = dlt_sh;
        byte_index_next      = bi_inc;
        bytes_left_next      = bl_dec;
        if (bl_dec == 4'd0) begin
          complete = 1'b1;
        end else if (last_byte) begin
          push.n     = 2'd1;
          push.r0    = final_result(KIND_CORRUPT);
          phase_next = PH_DONE;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (complete) begin
      if (run_bad) begin
        push.n     = 2'd1;
        push.r0    = final_result(KIND_CORRUPT);
        phase_next = PH_DONE;
      end else begin
        running_vcn_next = vsum[63:0];
        if (!sparse) begin
          running_lcn_next = lsum[63:0];
        end
        run_total_next          = rt_inc;
        phase_next              = PH_HEADER;
        push.n                  = 2'd1;
        push.r0                 = '0;
        push.r0.kind            = KIND_RUN;
        push.r0.run_vcn         = rv_e;
        push.r0.run_clusters    = cnt_use;
        push.r0.run_lcn         = sparse ? 64'd0 : lsum[63:0];
        push.r0.is_sparse       = sparse;
        if (last_byte) begin
          push.n     = 2'd2;
          push.r1    = final_result(end_kind(1'b1, cfg_regs, vsum[63:0]));
          phase_next = PH_DONE;
        end
      end
    end

    if (!accept) begin
      push = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      bytes_left      <= 4'd0;
      off_bytes       <= 4'd0;
      byte_index      <= 3'd0;
      assembled_count <= 64'd0;
      assembled_delta <= 64'd0;
      running_vcn     <= 64'd0;
      running_lcn     <= 64'd0;
      run_total       <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      bytes_left      <= bytes_left_next;
      off_bytes       <= off_bytes_next;
      byte_index      <= byte_index_next;
      assembled_count <= assembled_count_next;
      assembled_delta <= assembled_delta_next;
      running_vcn     <= running_vcn_next;
      running_lcn     <= running_lcn_next;
      run_total       <= run_total_next;
    end
  end

endmodule

`default_nettype wire

[design/ntfsrl_resq.sv]
`default_nettype none

module ntfsrl_resq (
  input  logic                 clk,
  input  logic                 rst,
  input  ntfsrl_pkg::push_t    push,
  input  logic                 pop,
  output ntfsrl_pkg::result_t  head,
  output logic                 head_valid,
  output logic                 room
);
  import ntfsrl_pkg::*;

  result_t    q [4];
  result_t    q_next [4];
  logic [2:0] count, count_pop, count_next;

  assign count_pop  = count - {2'b00, pop};
  assign count_next = count_pop + {1'b0, push.n};
  assign head       = q[0];
  assign head_valid = (count != 3'd0);
  // Two free entries cover the worst case of one byte.
  assign room       = (count <= 3'd2);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_next[i] = pop ? q[i + 1] : q[i];
    end
    q_next[3] = q[3];
    for (int i = 0; i < 4; i++) begin
      if (push.n != 2'd0 && 3'(i) == count_pop) begin
        q_next[i] = push.r0;
      end
      if (push.n == 2'd2 && 3'(i) == count_pop + 3'd1) begin
        q_next[i] = push.r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      q[i] <= q_next[i];
    end
  end

endmodule

`default_nettype wire

[design/ntfs_runlist_decoder_unit.sv]
`default_nettype none

// Channel   Role  Payload                                              Transaction
// runlist   sink  data_byte, first_byte, last_byte                     valid & ready
// result    src   kind, run_vcn, run_clusters, run_lcn, is_sparse,     valid & ready
//                 final_res
// cfg       sink  index, data                                          valid & ready
//
// One run list byte is decoded per cycle while runlist.ready is high; a byte's
// results reach the result queue on the edge that takes the byte; the result
// channel shows the queue head. The queue holds four results, and runlist.ready
// is low only while fewer than two entries are free. The cfg channel is always
// ready. Reset clears the decode state, the queue and both registers.

module ntfs_runlist_decoder_unit #(
  parameter int MAX_RUNS = 65536
) (
  input  logic          clk,
  input  logic          rst,
  ntfsrl_in_if.sink     runlist,
  ntfsrl_out_if.source  result,
  ntfsrl_cfg_if.sink    cfg
);
  import ntfsrl_pkg::*;

  cfg_t    cfg_regs;
  push_t   push;
  result_t head;
  logic    head_valid, room, accept, pop;

  assign cfg.ready     = 1'b1;
  assign runlist.ready = room;
  assign accept        = runlist.valid && room;
  assign pop           = head_valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.start_vcn <= 64'd0;
      cfg_regs.end_vcn   <= 64'd0;
      cfg_regs.end_p1    <= 64'd1;
      cfg_regs.end_max   <= 1'b0;
    end else if (cfg.valid) begin
      if (cfg.index == REG_START_VCN) begin
        cfg_regs.start_vcn <= cfg.data;
      end
      if (cfg.index == REG_END_VCN) begin
        cfg_regs.end_vcn <= cfg.data;
        cfg_regs.end_p1  <= cfg.data + 64'd1;
        cfg_regs.end_max <= &cfg.data;
      end
    end
  end

  ntfsrl_core #(
    .MAX_RUNS(MAX_RUNS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (runlist.data_byte),
    .first_byte (runlist.first_byte),
    .last_byte  (runlist.last_byte),
    .cfg_regs   (cfg_regs),
    .push       (push)
  );

  ntfsrl_resq u_resq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .room       (room)
  );

  assign result.valid        = head_valid;
  assign result.kind         = head.kind;
  assign result.run_vcn      = head.run_vcn;
  assign result.run_clusters = head.run_clusters;
  assign result.run_lcn      = head.run_lcn;
  assign result.is_sparse    = head.is_sparse;
  assign result.final_res    = head.final_res;

endmodule

`default_nettype wire
